[design/pops_pkg.sv]
// ----------------------------------------------------------------------------
// pops_pkg: shared definitions of the parallel one-pole smoothing filter
// Widths, reset values, register and command codes, payload and control
// structs used by the configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
package pops_pkg;

	localparam int MAX_CHANNELS        = 8;
	localparam int STATE_FRACTION_BITS = 32;
	localparam int NUM_POLES           = 3;

	localparam int SAMPLE_W      = 16;
	localparam int CHANNEL_OUT_W = 3;
	localparam int COUNT_W       = 4;
	localparam int POLE_W        = 32;
	localparam int GAIN_W        = 48;
	localparam int GAIN_FRAC     = 24;
	localparam int ACC_W         = 64;

	// shared unsigned multiplier
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// gain product magnitude and the sum of three signed products
	localparam int PM_W      = GAIN_W + ACC_W;
	localparam int SUM_W     = PM_W + 2;
	localparam int OUT_SHIFT = GAIN_FRAC + STATE_FRACTION_BITS;
	localparam int HI_W      = SUM_W - OUT_SHIFT;

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SEL_W  = $clog2(NUM_POLES);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int SAT_POS     = 32767;
	localparam int SAT_NEG_MAG = 32768;

	localparam logic [POLE_W-1:0]  POLE_A_RST        = POLE_W'(32'd4191888081);
	localparam logic [POLE_W-1:0]  POLE_B_RST        = POLE_W'(32'd4187696193);
	localparam logic [POLE_W-1:0]  POLE_C_RST        = POLE_W'(32'd4183508497);
	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = COUNT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_A,
		REG_POLE_B,
		REG_POLE_C,
		REG_GAIN_A,
		REG_GAIN_B,
		REG_GAIN_C,
		REG_CHANNEL_COUNT
	} pops_reg_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_POLE_LO,
		MUL_POLE_HI,
		MUL_G00,
		MUL_G01,
		MUL_G10,
		MUL_G11
	} pops_mul_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       restart;
	} pops_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
		logic [CHANNEL_OUT_W-1:0]   channel_of_sample;
	} pops_out_t;

	typedef struct packed {
		logic [NUM_POLES-1:0][POLE_W-1:0] pole;
		logic [NUM_POLES-1:0][GAIN_W-1:0] gain;
		logic [COUNT_W-1:0]               channel_count;
	} pops_cfg_t;

	typedef struct packed {
		logic             capture;
		logic             load;
		logic             add_sum;
		logic             update;
		logic             gmag;
		pops_mul_t        mul;
		logic [SEL_W-1:0] sel;
		logic             norm;
		logic             finish;
	} pops_cmd_t;

	typedef struct packed {
		logic out_free;
	} pops_sts_t;

endpackage

[design/pops_regs.sv]
// ----------------------------------------------------------------------------
// pops_regs: configuration registers
// Poles, gains and channel count, written one at a time over the
// configuration channel; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pops_regs import pops_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pops_cfg_t             cfg
);

	pops_cfg_t cfg_q;
	pops_reg_t reg_idx;

	assign cfg_ready = 1'b1;
	assign reg_idx   = pops_reg_t'(cfg_index);
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pole[0]        <= POLE_A_RST;
			cfg_q.pole[1]        <= POLE_B_RST;
			cfg_q.pole[2]        <= POLE_C_RST;
			cfg_q.gain           <= '0;
			cfg_q.channel_count  <= CHANNEL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx)
				REG_POLE_A:        cfg_q.pole[0] <= cfg_data[POLE_W-1:0];
				REG_POLE_B:        cfg_q.pole[1] <= cfg_data[POLE_W-1:0];
				REG_POLE_C:        cfg_q.pole[2] <= cfg_data[POLE_W-1:0];
				REG_GAIN_A:        cfg_q.gain[0] <= cfg_data[GAIN_W-1:0];
				REG_GAIN_B:        cfg_q.gain[1] <= cfg_data[GAIN_W-1:0];
				REG_GAIN_C:        cfg_q.gain[2] <= cfg_data[GAIN_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[design/pops_ctrl.sv]
// ----------------------------------------------------------------------------
// pops_ctrl: sequencer of the smoothing filter
// Walks each request through the three poles: pole update on the shared
// multiplier, gain product, then truncation and saturation of the sum.
// ----------------------------------------------------------------------------
module pops_ctrl import pops_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  pops_sts_t sts,
	output pops_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_PLO,
		S_PHI,
		S_PWAIT,
		S_UPD,
		S_GMAG,
		S_G00,
		S_G01,
		S_G10,
		S_G11,
		S_GWAIT,
		S_ADD,
		S_NORM,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [SEL_W-1:0] sel_q;
	logic             busy_q;

	assign sample_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_LOAD;
						sel_q   <= '0;
						busy_q  <= 1'b1;
					end
				end
				S_LOAD:  state_q <= S_PLO;
				S_PLO:   state_q <= S_PHI;
				S_PHI:   state_q <= S_PWAIT;
				S_PWAIT: state_q <= S_UPD;
				S_UPD:   state_q <= S_GMAG;
				S_GMAG:  state_q <= S_G00;
				S_G00:   state_q <= S_G01;
				S_G01:   state_q <= S_G10;
				S_G10:   state_q <= S_G11;
				S_G11:   state_q <= S_GWAIT;
				S_GWAIT: begin
					if (sel_q == SEL_W'(NUM_POLES - 1)) begin
						state_q <= S_ADD;
					end else begin
						state_q <= S_LOAD;
						sel_q   <= sel_q + SEL_W'(1);
					end
				end
				S_ADD:   state_q <= S_NORM;
				S_NORM:  state_q <= S_OUT;
				S_OUT: begin
					// hold until the result register is free
					if (sts.out_free) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.mul = MUL_NONE;
		cmd.sel = sel_q;
		unique case (state_q)
			S_IDLE:  cmd.capture = sample_valid;
			S_LOAD: begin
				cmd.load    = 1'b1;
				// fold in the previous pole's gain product
				cmd.add_sum = (sel_q != '0);
			end
			S_PLO:   cmd.mul     = MUL_POLE_LO;
			S_PHI:   cmd.mul     = MUL_POLE_HI;
			S_PWAIT: ;
			S_UPD:   cmd.update  = 1'b1;
			S_GMAG:  cmd.gmag    = 1'b1;
			S_G00:   cmd.mul     = MUL_G00;
			S_G01:   cmd.mul     = MUL_G01;
			S_G10:   cmd.mul     = MUL_G10;
			S_G11:   cmd.mul     = MUL_G11;
			S_GWAIT: ;
			S_ADD:   cmd.add_sum = 1'b1;
			S_NORM:  cmd.norm    = 1'b1;
			S_OUT:   cmd.finish  = sts.out_free;
			default: ;
		endcase
	end

endmodule

[design/pops_dp.sv]
// ----------------------------------------------------------------------------
// pops_dp: datapath of the smoothing filter
// Per-channel accumulators, one shared 32x32 multiplier with a product
// stage, pole update with saturation, gain sum and output saturation.
// ----------------------------------------------------------------------------
module pops_dp import pops_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pops_cfg_t cfg,
	input  pops_in_t  sample,
	input  pops_cmd_t cmd,
	output pops_sts_t sts,
	output logic      result_valid,
	input  logic      result_stall,
	output pops_out_t result
);

	// item state
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [CH_W-1:0]            ch_q;
	logic [CH_W-1:0]            pos_q;

	// accumulators; an entry whose valid bit is clear reads as zero
	logic [ACC_W-1:0]        acc_q [NUM_POLES][MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] acc_vld_q [NUM_POLES];

	logic [ACC_W-1:0]  r_q;
	logic [ACC_W-1:0]  m_q;
	logic [ACC_W-1:0]  t_q;
	logic              rneg_q;
	logic              pneg_q;
	logic [GAIN_W-1:0] gmag_q;
	logic [PROD_W-1:0] prod_s1;
	pops_mul_t         mul_s1;
	logic [PM_W-1:0]   pm_q;
	logic [SUM_W-1:0]  sum_q;
	logic [HI_W-1:0]   shi_q;
	logic              sneg_q;

	pops_out_t result_q;
	logic      result_valid_q;

	// combinational
	logic [NCH_W-1:0]  n_eff;
	logic [CH_W-1:0]   pos_cur;
	logic [CH_W-1:0]   ch_new;
	logic [CH_W-1:0]   pos_next;
	logic [ACC_W-1:0]  acc_rd;
	logic [ACC_W-1:0]  acc_rd_mag;
	logic [ACC_W-1:0]  r_mag;
	logic [GAIN_W-1:0] gain_sel;
	logic [GAIN_W-1:0] gain_mag;
	logic [POLE_W-1:0] pole_sel;
	logic [ACC_W-1:0]  s_fix;
	logic [ACC_W-1:0]  t_x;
	logic [ACC_W:0]    upd_sum;
	logic [ACC_W-1:0]  upd_val;
	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [SUM_W-1:0]  pm_x;
	logic [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]  sum_mag;
	logic              clip;
	logic signed [SAMPLE_W-1:0] out_val;

	assign sts.out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// channel selection at capture
	always_comb begin
		if (cfg.channel_count == '0) begin
			n_eff = NCH_W'(1);
		end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
			n_eff = NCH_W'(MAX_CHANNELS);
		end else begin
			n_eff = NCH_W'(cfg.channel_count);
		end
		pos_cur  = sample.restart ? '0 : pos_q;
		ch_new   = (NCH_W'(pos_cur) < n_eff) ? pos_cur : '0;
		pos_next = ((NCH_W'(ch_new) + NCH_W'(1)) >= n_eff) ? '0
			: CH_W'(NCH_W'(ch_new) + NCH_W'(1));
	end

	// operand fetch and magnitudes
	always_comb begin
		acc_rd     = acc_vld_q[cmd.sel][ch_q] ? acc_q[cmd.sel][ch_q] : '0;
		acc_rd_mag = acc_rd[ACC_W-1] ? (~acc_rd + ACC_W'(1)) : acc_rd;
		r_mag      = r_q[ACC_W-1] ? (~r_q + ACC_W'(1)) : r_q;
		gain_sel   = cfg.gain[cmd.sel];
		gain_mag   = gain_sel[GAIN_W-1] ? (~gain_sel + GAIN_W'(1)) : gain_sel;
		pole_sel   = cfg.pole[cmd.sel];
	end

	// pole update: sample + (+/-t), saturated to the accumulator range
	always_comb begin
		s_fix = {{(ACC_W-SAMPLE_W-STATE_FRACTION_BITS){sample_q[SAMPLE_W-1]}},
			sample_q, {STATE_FRACTION_BITS{1'b0}}};
		t_x     = t_q ^ {ACC_W{rneg_q}};
		upd_sum = {s_fix[ACC_W-1], s_fix} + {t_x[ACC_W-1], t_x}
			+ (ACC_W+1)'(rneg_q);
		if (upd_sum[ACC_W] != upd_sum[ACC_W-1]) begin
			upd_val = {upd_sum[ACC_W], {(ACC_W-1){!upd_sum[ACC_W]}}};
		end else begin
			upd_val = upd_sum[ACC_W-1:0];
		end
	end

	// multiplier operand selection
	always_comb begin
		unique case (cmd.mul)
			MUL_POLE_LO: begin op_a = m_q[MUL_W-1:0];       op_b = pole_sel; end
			MUL_POLE_HI: begin op_a = m_q[ACC_W-1:MUL_W];   op_b = pole_sel; end
			MUL_G00: begin op_a = gmag_q[MUL_W-1:0];        op_b = m_q[MUL_W-1:0]; end
			MUL_G01: begin op_a = gmag_q[MUL_W-1:0];        op_b = m_q[ACC_W-1:MUL_W]; end
			MUL_G10: begin
				op_a = MUL_W'(gmag_q[GAIN_W-1:MUL_W]);
				op_b = m_q[MUL_W-1:0];
			end
			MUL_G11: begin
				op_a = MUL_W'(gmag_q[GAIN_W-1:MUL_W]);
				op_b = m_q[ACC_W-1:MUL_W];
			end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// sum of signed gain products and output saturation
	always_comb begin
		pm_x     = SUM_W'(pm_q) ^ {SUM_W{pneg_q}};
		sum_next = sum_q + pm_x + SUM_W'(pneg_q);
		sum_mag  = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
		if (sneg_q) begin
			clip    = shi_q > HI_W'(SAT_NEG_MAG);
			out_val = clip ? SAMPLE_W'(-SAT_NEG_MAG) : -shi_q[SAMPLE_W-1:0];
		end else begin
			clip    = shi_q > HI_W'(SAT_POS);
			out_val = clip ? SAMPLE_W'(SAT_POS) : shi_q[SAMPLE_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			mul_s1         <= MUL_NONE;
			result_valid_q <= 1'b0;
			for (int j = 0; j < NUM_POLES; j++) begin
				acc_vld_q[j] <= '0;
			end
		end else begin
			mul_s1 <= cmd.mul;
			if (cmd.capture) begin
				pos_q <= pos_next;
				if (sample.restart) begin
					for (int j = 0; j < NUM_POLES; j++) begin
						acc_vld_q[j] <= '0;
					end
				end
			end
			if (cmd.update) begin
				acc_vld_q[cmd.sel][ch_q] <= 1'b1;
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);

		if (cmd.capture) begin
			sample_q <= sample.sample_in;
			ch_q     <= ch_new;
			sum_q    <= '0;
		end

		if (cmd.load) begin
			m_q    <= acc_rd_mag;
			rneg_q <= acc_rd[ACC_W-1];
			t_q    <= '0;
		end else if (mul_s1 == MUL_POLE_LO) begin
			t_q <= t_q + (prod_s1 >> POLE_W);
		end else if (mul_s1 == MUL_POLE_HI) begin
			t_q <= t_q + prod_s1;
		end else if (cmd.gmag) begin
			m_q <= r_mag;
		end

		if (cmd.update) begin
			acc_q[cmd.sel][ch_q] <= upd_val;
			r_q                  <= upd_val;
		end

		if (cmd.gmag) begin
			gmag_q <= gain_mag;
			pneg_q <= r_q[ACC_W-1] ^ gain_sel[GAIN_W-1];
			pm_q   <= '0;
		end else begin
			case (mul_s1) inside
				MUL_G00:          pm_q <= pm_q + PM_W'(prod_s1);
				MUL_G01, MUL_G10: pm_q <= pm_q + (PM_W'(prod_s1) << MUL_W);
				MUL_G11:          pm_q <= pm_q + (PM_W'(prod_s1) << (2 * MUL_W));
				default: ;
			endcase
		end

		if (cmd.add_sum) begin
			sum_q <= sum_next;
		end

		if (cmd.norm) begin
			sneg_q <= sum_q[SUM_W-1];
			shi_q  <= sum_mag[SUM_W-1:OUT_SHIFT];
		end

		if (cmd.finish) begin
			result_q.sample_out        <= out_val;
			result_q.clipped           <= clip;
			result_q.channel_of_sample <= CHANNEL_OUT_W'(ch_q);
		end
	end

endmodule

[design/parallel_one_pole_smoothing_filter.sv]
// ----------------------------------------------------------------------------
// parallel_one_pole_smoothing_filter: three one-pole low-pass smoothers
// Interleaved 16-bit samples in, weighted sum of three one-pole
// accumulators per channel out, saturated to 16 bits with a clip flag.
//
// Sample channel: sample_valid / sample_stall, payload sample (sample_in,
// restart). A request is taken when valid is high and stall is low. Set
// restart on the first sample of a buffer to clear every accumulator and
// restart the channel rotation at channel zero.
// Result channel: result_valid / result_stall, payload result (sample_out,
// clipped, channel_of_sample); one result per sample, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; write
// only while no sample is in flight. cfg_ready is always high.
//
// Each sample's eighteen 32x32 partial products (two per pole update, four
// per gain product, three poles) go through one shared multiplier with a
// product register. The next sample is taken in the cycle after the result
// is loaded; no new sample is taken while one is being worked on.
// A stalled result holds in the output register; the next sample is still
// accepted and worked on, and waits in its last step until the register frees.
// Reset clears the accumulators, the channel counter and loads the default
// poles, zero gains and a channel count of one.
// ----------------------------------------------------------------------------
module parallel_one_pole_smoothing_filter import pops_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  pops_in_t              sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output pops_out_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pops_cfg_t cfg;
	pops_cmd_t cmd;
	pops_sts_t sts;

	pops_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pops_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	pops_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample       (sample),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[design/pops_chk.sv]
// ----------------------------------------------------------------------------
// pops_chk: port checker of the smoothing filter
// Watches the top-level handshakes for ordering between requests and
// results, and the saturation flag against the output value.
// ----------------------------------------------------------------------------
module pops_chk import pops_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      sample_valid,
	input logic      sample_stall,
	input logic      result_valid,
	input logic      result_stall,
	input pops_out_t result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// a taken request keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input not stalled after a request was taken");

	// a new result comes only from a request in flight
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result without a request in flight");

	// the input frees only when the finished result is shown
	a_release_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_stall) |-> result_valid)
		else $error("input released without a result");

	// a clipped result sits at one of the limits
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clipped |->
			(result.sample_out == SAMPLE_W'(SAT_POS)) ||
			(result.sample_out == SAMPLE_W'(-SAT_NEG_MAG)))
		else $error("clipped result not at a limit");

endmodule

bind parallel_one_pole_smoothing_filter pops_chk u_pops_chk (.*);

[dv/pops_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pops_checker: scoreboard of the parallel one-pole smoothing filter
// Watches the sample, result and configuration channels, keeps its own
// copy of the registers and the per-channel accumulators, predicts each
// filtered sample and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module pops_checker import pops_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_stall,
	input  pops_in_t              sample,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  pops_out_t             result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	logic        [POLE_W-1:0]  pole [NUM_POLES];
	logic signed [GAIN_W-1:0]  gain [NUM_POLES];
	logic        [COUNT_W-1:0] chan_count;
	logic signed [ACC_W-1:0]   acc [NUM_POLES][MAX_CHANNELS];
	int                        chan_pos;
	pops_out_t                 smoothed_q [$];
	pops_out_t                 oldest;

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (pops_reg_t'(idx))
			REG_POLE_A:        pole[0] = value[POLE_W-1:0];
			REG_POLE_B:        pole[1] = value[POLE_W-1:0];
			REG_POLE_C:        pole[2] = value[POLE_W-1:0];
			REG_GAIN_A:        gain[0] = value[GAIN_W-1:0];
			REG_GAIN_B:        gain[1] = value[GAIN_W-1:0];
			REG_GAIN_C:        gain[2] = value[GAIN_W-1:0];
			REG_CHANNEL_COUNT: chan_count = value[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// reg = pole * reg + sample, product truncated toward zero, sum saturated
	function automatic logic signed [ACC_W-1:0] pole_update(input logic signed [ACC_W-1:0] r,
			input logic [POLE_W-1:0] p, input logic signed [SAMPLE_W-1:0] x);
		logic [ACC_W-1:0]       m;
		logic [ACC_W+POLE_W-1:0] prod;
		logic signed [ACC_W:0]  scaled;
		logic signed [ACC_W:0]  inc;
		logic signed [ACC_W:0]  total;
		m = r[ACC_W-1] ? -r : r;
		prod = {{POLE_W{1'b0}}, m} * {{ACC_W{1'b0}}, p};
		scaled = $signed({1'b0, prod[ACC_W+POLE_W-1:POLE_W]});
		if (r[ACC_W-1])
			scaled = -scaled;
		inc = {{(ACC_W+1-SAMPLE_W-STATE_FRACTION_BITS){x[SAMPLE_W-1]}}, x,
			{STATE_FRACTION_BITS{1'b0}}};
		total = scaled + inc;
		if (total[ACC_W] != total[ACC_W-1])
			return total[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return total[ACC_W-1:0];
	endfunction

	// weighted sum of the three accumulators, truncated and saturated
	function automatic pops_out_t weigh_channel(input int ch);
		logic signed [127:0]         total;
		logic signed [127:0]         g;
		logic signed [127:0]         a;
		logic [127:0]                mag;
		logic [127:0]                q;
		logic                        neg;
		logic                        clip;
		logic signed [SAMPLE_W-1:0]  val;
		pops_out_t                   res;
		total = '0;
		for (int i = 0; i < NUM_POLES; i++) begin
			g = gain[i];
			a = acc[i][ch];
			total = total + g * a;
		end
		neg = total[127];
		mag = neg ? -total : total;
		q = mag >> OUT_SHIFT;
		if (neg) begin
			clip = q > SAT_NEG_MAG;
			val = clip ? 16'sh8000 : -q[SAMPLE_W-1:0];
		end else begin
			clip = q > SAT_POS;
			val = clip ? 16'sh7FFF : q[SAMPLE_W-1:0];
		end
		res = '0;
		res.sample_out = val;
		res.clipped = clip;
		return res;
	endfunction

	function automatic pops_out_t filter_sample(input pops_in_t item);
		int        n;
		int        ch;
		pops_out_t res;
		if (chan_count == 0)
			n = 1;
		else if (chan_count > MAX_CHANNELS)
			n = MAX_CHANNELS;
		else
			n = int'(chan_count);
		if (item.restart) begin
			for (int i = 0; i < NUM_POLES; i++)
				for (int c = 0; c < MAX_CHANNELS; c++)
					acc[i][c] = '0;
			chan_pos = 0;
		end
		// a counter left beyond a lowered count falls back to channel zero
		ch = (chan_pos < n) ? chan_pos : 0;
		for (int i = 0; i < NUM_POLES; i++)
			acc[i][ch] = pole_update(acc[i][ch], pole[i], item.sample_in);
		res = weigh_channel(ch);
		res.channel_of_sample = CHANNEL_OUT_W'(ch);
		chan_pos = (ch + 1 >= n) ? 0 : ch + 1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole[0] = POLE_A_RST;
			pole[1] = POLE_B_RST;
			pole[2] = POLE_C_RST;
			for (int i = 0; i < NUM_POLES; i++) begin
				gain[i] = '0;
				for (int c = 0; c < MAX_CHANNELS; c++)
					acc[i][c] = '0;
			end
			chan_count = CHANNEL_COUNT_RST;
			chan_pos = 0;
			smoothed_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (result_valid && !result_stall) begin
				if (smoothed_q.size() == 0) begin
					report("result with no request pending, sample_out", result.sample_out, 0);
				end else begin
					oldest = smoothed_q.pop_front();
					if (result.sample_out !== oldest.sample_out)
						report("sample_out", result.sample_out, oldest.sample_out);
					if (result.clipped !== oldest.clipped)
						report("clipped", result.clipped, oldest.clipped);
					if (result.channel_of_sample !== oldest.channel_of_sample)
						report("channel_of_sample", result.channel_of_sample,
							oldest.channel_of_sample);
				end
			end
			if (sample_valid && !sample_stall)
				smoothed_q.push_back(filter_sample(sample));
			outstanding = smoothed_q.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the parallel one-pole smoothing filter
// Drives directed and random sample streams under several register
// settings, with random gaps and result stalls; a separate checker
// predicts and compares every result and hands back its mismatch count.
// ----------------------------------------------------------------------------
module tb;
	import pops_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [GAIN_W-1:0]    GAIN_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam logic [GAIN_W-1:0]    GAIN_MIN   = 48'h8000_0000_0000;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	pops_in_t              sample;
	logic                  result_valid;
	logic                  result_stall;
	pops_out_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	bit                    calm;

	parallel_one_pole_smoothing_filter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pops_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: short random stalls, now and then one long enough to hold a result
	initial begin : result_sink
		int hold;
		hold = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (calm) begin
				hold = 0;
				result_stall <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if ($urandom_range(1999) == 0) begin
				hold = $urandom_range(80, 40);
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < 9);
			end
		end
	end

	task automatic send(input logic signed [SAMPLE_W-1:0] value, input logic first);
		if (!calm && $urandom_range(99) < 9) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(45, 1)) @(posedge clk);
		end
		sample <= '{sample_in: value, restart: first};
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// drop valid and hold until every result is back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// unused upper data bits are random, the block must mask them
	task automatic set_all(input logic [POLE_W-1:0] pa, input logic [POLE_W-1:0] pb,
			input logic [POLE_W-1:0] pc, input logic [GAIN_W-1:0] ga,
			input logic [GAIN_W-1:0] gb, input logic [GAIN_W-1:0] gc,
			input logic [COUNT_W-1:0] cnt);
		write_reg(REG_POLE_A, {(CFG_DATA_W-POLE_W)'($urandom), pa});
		write_reg(REG_POLE_B, {(CFG_DATA_W-POLE_W)'($urandom), pb});
		write_reg(REG_POLE_C, {(CFG_DATA_W-POLE_W)'($urandom), pc});
		write_reg(REG_GAIN_A, ga);
		write_reg(REG_GAIN_B, gb);
		write_reg(REG_GAIN_C, gc);
		write_reg(REG_CHANNEL_COUNT, {(CFG_DATA_W-COUNT_W)'({$urandom, $urandom}), cnt});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [POLE_W-1:0] rand_pole();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return {4'hF, 28'($urandom)};
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		logic signed [GAIN_W-1:0] g;
		g = GAIN_W'({$urandom, $urandom});
		case ($urandom_range(9))
			0: return '0;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			default: return g >>> $urandom_range(46, 20);
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] rand_count();
		case ($urandom_range(9))
			0: return '0;
			1: return 4'd1;
			2: return 4'd8;
			3: return COUNT_W'($urandom_range(15, 9));
			default: return COUNT_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic signed [SAMPLE_W-1:0] s;
		s = SAMPLE_W'($urandom);
		case ($urandom_range(11))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return s >>> $urandom_range(14, 6);
			default: return s;
		endcase
	endfunction

	initial begin : stimulus
		logic first;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero gains, so every output is zero
		send(16'sh7FFF, 1'b1);
		send(16'sh8000, 1'b0);
		send(16'sh0001, 1'b0);
		drain();

		// unit, minus half and quarter gains over three channels
		set_all(POLE_A_RST, POLE_B_RST, POLE_C_RST, 48'h0000_0100_0000,
			48'hFFFF_FF80_0000, 48'h0000_0040_0000, 4'd3);
		send(16'sh7FFF, 1'b1);
		send(16'sh7FFF, 1'b0);
		send(16'sh8000, 1'b0);
		send(16'sh7FFF, 1'b0);
		send(16'sh8000, 1'b0);
		send(16'sh0000, 1'b1);
		drain();

		// lower the count while the counter stands beyond it
		write_reg(REG_CHANNEL_COUNT, 48'd8);
		cfg_valid <= 1'b0;
		send(16'sh1234, 1'b1);
		repeat (4) send(rand_sample(), 1'b0);
		drain();
		write_reg(REG_CHANNEL_COUNT, 48'd3);
		cfg_valid <= 1'b0;
		send(16'sh4000, 1'b0);
		send(16'shC000, 1'b0);
		drain();

		// a count of zero acts as one channel
		write_reg(REG_CHANNEL_COUNT, 48'd0);
		cfg_valid <= 1'b0;
		send(16'sh7FFF, 1'b0);
		send(16'sh8000, 1'b0);
		drain();

		// an unknown index is ignored; extreme poles and gains, count above the maximum
		write_reg(REG_UNUSED, '1);
		set_all('0, '1, POLE_C_RST, GAIN_MAX, GAIN_MIN, GAIN_MAX, 4'd15);
		send(16'sh7FFF, 1'b1);
		send(16'sh8000, 1'b0);
		send(16'shFFFF, 1'b0);

		for (int phase = 0; phase < 5; phase++) begin
			drain();
			calm = (phase == 2);
			if ($urandom_range(3) == 0) begin
				write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
				cfg_valid <= 1'b0;
			end
			set_all(rand_pole(), rand_pole(), rand_pole(), rand_gain(), rand_gain(),
				rand_gain(), rand_count());
			for (int k = 0; k < 80; k++) begin
				first = (k == 0) || ($urandom_range(19) == 0);
				if ($urandom_range(39) == 0)
					drain();
				send(rand_sample(), first);
			end
		end
		calm = 1'b0;

		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
